// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the batch scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define HBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hbs check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define HBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hbs check failed: next-cycle implication");

`endif

// ----- rtl/core/hbs_pkg.sv -----
// Package with the field widths and the controller/datapath handshake types.
`default_nettype none

package hbs_pkg;

	// Fixed widths of the channel fields.
	localparam int PHASE_W   = 2;
	localparam int MASK_W    = 64;
	localparam int TASK_IDX_W = 5;
	localparam int BATCH_W   = 5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;        // store the incoming record and update the edge matrix
		logic pick;        // register the next batch of the current phase
		logic phase_next;  // current phase has nothing open, move on
		logic emit;        // move the lowest task of the batch to the output register
		logic clear;       // schedule finished, return to an empty store
	} hbs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic phase_empty;    // no open task in the current phase
		logic slot_free;      // output register can take a result this cycle
		logic last_in_batch;  // task about to be emitted closes its batch
		logic last_in_sched;  // task about to be emitted closes the schedule
	} hbs_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/hbs_if.sv -----
// Valid/ready channel interfaces for task records and schedule results.
`default_nettype none

interface hbs_task_if import hbs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [PHASE_W-1:0]  task_phase;
	logic [MASK_W-1:0]   read_mask;
	logic [MASK_W-1:0]   write_mask;
	logic                last_task;

	modport source (output valid, task_phase, read_mask, write_mask, last_task,
		input ready);
	modport sink (input valid, task_phase, read_mask, write_mask, last_task,
		output ready);
endinterface

interface hbs_result_if import hbs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [TASK_IDX_W-1:0] task_index;
	logic [BATCH_W-1:0]    batch_number;
	logic                  end_of_batch;
	logic                  cycle_forced;
	logic                  end_of_schedule;

	modport source (output valid, task_index, batch_number, end_of_batch, cycle_forced,
		end_of_schedule, input ready);
	modport sink (input valid, task_index, batch_number, end_of_batch, cycle_forced,
		end_of_schedule, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hazard_batch_scheduler_unit.sv -----
// Top level of the hazard batch scheduler: controller plus datapath.
//
//   Channel   Direction  Carries
//   tasks     in         task_phase, read_mask, write_mask, last_task
//   results   out        task_index, batch_number, end_of_batch, cycle_forced,
//                        end_of_schedule
//
// A record is taken when valid and ready meet; its hazard edges against all
// held records are formed in that same cycle. After the last record, each
// batch is selected in the pick state, which also skips empty phases, and its
// tasks leave one at a time through the output register. Asynchronous reset
// clears the control state; the task store and edge matrix are not cleared
// and are only read below the fill count. Stalled results hold the emission.
`default_nettype none

module hazard_batch_scheduler_unit import hbs_pkg::*; #(
	parameter int MAX_TASKS   = 32,
	parameter int MASK_BITS   = 64,
	parameter int PHASE_COUNT = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	hbs_task_if.sink      tasks,
	hbs_result_if.source  results
);

	hbs_cmd_t cmd;
	hbs_sts_t sts;
	logic     task_ready;

	assign tasks.ready = task_ready;

	hbs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.task_valid (tasks.valid),
		.task_last  (tasks.last_task),
		.task_ready (task_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	hbs_datapath #(
		.MAX_TASKS   (MAX_TASKS),
		.MASK_BITS   (MASK_BITS),
		.PHASE_COUNT (PHASE_COUNT)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.task_phase      (tasks.task_phase),
		.read_mask       (tasks.read_mask),
		.write_mask      (tasks.write_mask),
		.out_valid       (results.valid),
		.out_ready       (results.ready),
		.task_index      (results.task_index),
		.batch_number    (results.batch_number),
		.end_of_batch    (results.end_of_batch),
		.cycle_forced    (results.cycle_forced),
		.end_of_schedule (results.end_of_schedule)
	);

endmodule

`default_nettype wire

// ----- rtl/core/hbs_ctrl.sv -----
// Controller state machine: record loading, batch selection and emission.
`default_nettype none

module hbs_ctrl import hbs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     task_valid,
	input  wire logic     task_last,
	output logic          task_ready,
	input  wire hbs_sts_t sts,
	output hbs_cmd_t      cmd
);

	typedef enum logic [1:0] {
		S_LOAD,
		S_PICK,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   ready_q;

	// Commands follow the state and the datapath status.
	assign task_ready     = ready_q;
	assign cmd.load       = task_valid & ready_q;
	assign cmd.pick       = (state_q == S_PICK) & ~sts.phase_empty;
	assign cmd.phase_next = (state_q == S_PICK) & sts.phase_empty;
	assign cmd.emit       = (state_q == S_EMIT) & sts.slot_free;
	assign cmd.clear      = cmd.emit & sts.last_in_sched;

	// State register with the registered ready.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (task_valid && ready_q && task_last) begin
						state_q <= S_PICK;
						ready_q <= 1'b0;
					end
				end
				S_PICK: begin
					if (!sts.phase_empty) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (sts.slot_free && sts.last_in_sched) begin
						state_q <= S_LOAD;
						ready_q <= 1'b1;
					end else if (sts.slot_free && sts.last_in_batch) begin
						state_q <= S_PICK;
					end
				end
				default: begin
					state_q <= S_LOAD;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hbs_datapath.sv -----
// Datapath: task store, hazard edge matrix, batch selection and output register.
`default_nettype none

module hbs_datapath import hbs_pkg::*; #(
	parameter int MAX_TASKS   = 32,
	parameter int MASK_BITS   = 64,
	parameter int PHASE_COUNT = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire hbs_cmd_t              cmd,
	output hbs_sts_t                   sts,
	input  wire logic [PHASE_W-1:0]    task_phase,
	input  wire logic [MASK_W-1:0]     read_mask,
	input  wire logic [MASK_W-1:0]     write_mask,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [TASK_IDX_W-1:0]      task_index,
	output logic [BATCH_W-1:0]         batch_number,
	output logic                       end_of_batch,
	output logic                       cycle_forced,
	output logic                       end_of_schedule
);

	localparam int IDX_W = $clog2(MAX_TASKS);
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	// Task store and edge matrix; pred_q[t] holds the predecessors of task t.
	logic [PHASE_W-1:0]   phase_st_q [MAX_TASKS];
	logic [MASK_BITS-1:0] rd_st_q    [MAX_TASKS];
	logic [MASK_BITS-1:0] wr_st_q    [MAX_TASKS];
	logic [MAX_TASKS-1:0] pred_q     [MAX_TASKS];

	logic [CNT_W-1:0]     count_q;
	logic [MAX_TASKS-1:0] done_q;
	logic [MAX_TASKS-1:0] batch_q;
	logic                 forced_q;
	logic [PHASE_W-1:0]   cur_phase_q;
	logic [BATCH_W-1:0]   batch_cnt_q;
	logic                 out_valid_q;

	logic [TASK_IDX_W-1:0] task_index_q;
	logic [BATCH_W-1:0]    batch_number_q;
	logic                  end_of_batch_q;
	logic                  cycle_forced_q;
	logic                  end_of_schedule_q;

	logic [PHASE_W-1:0]   p_new;
	logic [MASK_BITS-1:0] rd_new;
	logic [MASK_BITS-1:0] wr_new;
	logic [IDX_W-1:0]     wr_idx;
	logic                 store_room;
	logic [MAX_TASKS-1:0] pred_new;
	logic [MAX_TASKS-1:0] succ_new;
	logic [MAX_TASKS-1:0] held_v;
	logic [MAX_TASKS-1:0] open_v;
	logic [MAX_TASKS-1:0] ready_v;
	logic [MAX_TASKS-1:0] first_open;
	logic [MAX_TASKS-1:0] lo_onehot;
	logic [IDX_W-1:0]     lo_idx;
	logic                 last_in_batch;

	// Incoming record: saturate the phase and keep the low mask bits.
	always_comb begin
		if (int'(task_phase) >= PHASE_COUNT) begin
			p_new = PHASE_W'(PHASE_COUNT - 1);
		end else begin
			p_new = task_phase;
		end
	end
	assign rd_new     = read_mask[MASK_BITS-1:0];
	assign wr_new     = write_mask[MASK_BITS-1:0];
	assign wr_idx     = count_q[IDX_W-1:0];
	assign store_room = (count_q != CNT_W'(MAX_TASKS));

	// Hazards of the new record against every held record, all in parallel.
	always_comb begin
		for (int a = 0; a < MAX_TASKS; a++) begin
			held_v[a]   = (CNT_W'(a) < count_q);
			pred_new[a] = held_v[a] && (phase_st_q[a] == p_new) &&
				(|(wr_st_q[a] & (rd_new | wr_new)));
			succ_new[a] = (phase_st_q[a] == p_new) && (|(wr_new & rd_st_q[a]));
		end
	end

	// Open tasks of the current phase and those whose predecessors are all done.
	always_comb begin
		for (int t = 0; t < MAX_TASKS; t++) begin
			open_v[t] = held_v[t] && !done_q[t] && (phase_st_q[t] == cur_phase_q);
		end
		for (int t = 0; t < MAX_TASKS; t++) begin
			ready_v[t] = open_v[t] && !(|(pred_q[t] & open_v));
		end
	end
	assign first_open = open_v & (~open_v + MAX_TASKS'(1));

	// Lowest task still waiting in the registered batch.
	assign lo_onehot = batch_q & (~batch_q + MAX_TASKS'(1));
	always_comb begin
		lo_idx = '0;
		for (int t = MAX_TASKS - 1; t >= 0; t--) begin
			if (batch_q[t]) begin
				lo_idx = IDX_W'(t);
			end
		end
	end
	assign last_in_batch = ((batch_q & ~lo_onehot) == '0);

	assign sts.phase_empty   = (open_v == '0);
	assign sts.slot_free     = !out_valid_q || out_ready;
	assign sts.last_in_batch = last_in_batch;
	assign sts.last_in_sched = last_in_batch && (((done_q | lo_onehot) & held_v) == held_v);

	// Store and edge matrix writes; row of the new task, column for older tasks.
	always_ff @(posedge clk) begin
		if (cmd.load && store_room) begin
			phase_st_q[wr_idx] <= p_new;
			rd_st_q[wr_idx]    <= rd_new;
			wr_st_q[wr_idx]    <= wr_new;
			pred_q[wr_idx]     <= pred_new;
			for (int a = 0; a < MAX_TASKS; a++) begin
				if (held_v[a]) begin
					pred_q[a][wr_idx] <= succ_new[a];
				end
			end
		end
	end

	// Schedule control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			done_q      <= '0;
			batch_q     <= '0;
			forced_q    <= 1'b0;
			cur_phase_q <= '0;
			batch_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && store_room) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.phase_next) begin
				cur_phase_q <= cur_phase_q + PHASE_W'(1);
			end
			if (cmd.pick) begin
				if (ready_v != '0) begin
					batch_q  <= ready_v;
					forced_q <= 1'b0;
				end else begin
					batch_q  <= first_open;
					forced_q <= 1'b1;
				end
			end
			// Emitting the final task of a schedule returns the store to empty.
			if (cmd.clear) begin
				count_q     <= '0;
				done_q      <= '0;
				batch_q     <= '0;
				cur_phase_q <= '0;
				batch_cnt_q <= '0;
			end else if (cmd.emit) begin
				batch_q <= batch_q & ~lo_onehot;
				done_q  <= done_q | lo_onehot;
				if (last_in_batch) begin
					batch_cnt_q <= batch_cnt_q + BATCH_W'(1);
				end
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			task_index_q      <= TASK_IDX_W'(lo_idx);
			batch_number_q    <= batch_cnt_q;
			end_of_batch_q    <= last_in_batch;
			cycle_forced_q    <= forced_q;
			end_of_schedule_q <= sts.last_in_sched;
		end
	end

	assign out_valid       = out_valid_q;
	assign task_index      = task_index_q;
	assign batch_number    = batch_number_q;
	assign end_of_batch    = end_of_batch_q;
	assign cycle_forced    = cycle_forced_q;
	assign end_of_schedule = end_of_schedule_q;

endmodule

`default_nettype wire

// ----- rtl/core/hbs_checker.sv -----
// Port-level checker for the batch scheduler and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module hbs_checker import hbs_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  tasks_valid,
	input wire logic                  tasks_ready,
	input wire logic                  tasks_last,
	input wire logic                  results_valid,
	input wire logic                  results_ready,
	input wire logic [TASK_IDX_W-1:0] task_index,
	input wire logic [BATCH_W-1:0]    batch_number,
	input wire logic                  end_of_batch,
	input wire logic                  cycle_forced,
	input wire logic                  end_of_schedule
);

	// A stalled result keeps its valid and its payload.
	`HBS_ASSERT_NEXT(a_result_hold, clk, arst_n, results_valid && !results_ready, results_valid && $stable(task_index) && $stable(batch_number) && $stable(end_of_batch) && $stable(cycle_forced) && $stable(end_of_schedule))

	// While a schedule is still being emitted, no new record is taken.
	`HBS_ASSERT_NOW(a_no_load_mid_schedule, clk, arst_n, results_valid && !end_of_schedule, !tasks_ready)

	// The final record of a set closes the input for the schedule build.
	`HBS_ASSERT_NEXT(a_last_closes_input, clk, arst_n, tasks_valid && tasks_ready && tasks_last, !tasks_ready)

	// A batch forced out by a dependency cycle holds exactly one task.
	`HBS_ASSERT_NOW(a_forced_single, clk, arst_n, results_valid && cycle_forced, end_of_batch)

endmodule

bind hazard_batch_scheduler_unit hbs_checker u_hbs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.tasks_valid     (tasks.valid),
	.tasks_ready     (tasks.ready),
	.tasks_last      (tasks.last_task),
	.results_valid   (results.valid),
	.results_ready   (results.ready),
	.task_index      (results.task_index),
	.batch_number    (results.batch_number),
	.end_of_batch    (results.end_of_batch),
	.cycle_forced    (results.cycle_forced),
	.end_of_schedule (results.end_of_schedule)
);

`default_nettype wire

// ----- sim/hazard_batch_scheduler_unit_tb.sv -----
// Self-checking testbench for the hazard batch scheduler: directed and random traffic, predicted result order.
`timescale 1ns / 100ps

module hazard_batch_scheduler_unit_tb;
	import hbs_pkg::*;

	localparam int MAX_TASKS     = 32;
	localparam int MASK_BITS     = 64;
	localparam int PHASE_COUNT   = 4;
	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_ITEMS  = 210;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int QUIET_LIMIT   = 4000;
	localparam int PRINT_LIMIT   = 40;

	typedef struct packed {
		logic [PHASE_W-1:0] task_phase;
		logic [MASK_W-1:0]  read_mask;
		logic [MASK_W-1:0]  write_mask;
		logic               last_task;
	} task_rec_t;

	typedef struct packed {
		logic [TASK_IDX_W-1:0] task_index;
		logic [BATCH_W-1:0]    batch_number;
		logic                  end_of_batch;
		logic                  cycle_forced;
		logic                  end_of_schedule;
	} sched_entry_t;

	typedef enum logic [1:0] {FEED_RECORD, FEED_DRAIN, FEED_HOLD} feed_kind_t;

	typedef struct packed {
		feed_kind_t kind;
		task_rec_t  rec;
	} feed_item_t;

	typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_RHYTHM} sink_mode_t;

	logic clk;
	logic arst_n;

	hbs_task_if   tasks_ch ();
	hbs_result_if results_ch ();

	hazard_batch_scheduler_unit #(
		.MAX_TASKS  (MAX_TASKS),
		.MASK_BITS  (MASK_BITS),
		.PHASE_COUNT(PHASE_COUNT)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.tasks  (tasks_ch),
		.results(results_ch)
	);

	// Predictor copy of the task store.
	logic [PHASE_W-1:0] held_phase [MAX_TASKS];
	logic [MASK_W-1:0]  held_read  [MAX_TASKS];
	logic [MASK_W-1:0]  held_write [MAX_TASKS];
	int                 held_count;

	sched_entry_t planned_results [$];
	feed_item_t   feed_queue [$];

	int fail_count;
	int quiet_cycles;
	int hold_token;
	int res_pos [4];

	// Driver state.
	task_rec_t  on_offer;
	feed_item_t head;
	logic       offering;
	int         gap_left;
	int         burst_left;

	// Receiver state.
	sink_mode_t sink_mode;
	int         mode_left;
	int         hold_seen;
	int         hold_left;

	always #(CLK_HALF) clk = ~clk;

	task flag_mismatch(input string what);
		fail_count++;
		if (fail_count <= PRINT_LIMIT)
			$display("mismatch @%0t: %s", $time, what);
	endtask

	// Build the hazard graph of the held tasks and lay out the batches phase by phase.
	function automatic void plan_schedule();
		logic [MAX_TASKS-1:0] preds [MAX_TASKS];
		logic [MAX_TASKS-1:0] members;
		logic [MAX_TASKS-1:0] open_set;
		logic [MAX_TASKS-1:0] ready_set;
		logic [MAX_TASKS-1:0] done_set;
		logic [BATCH_W-1:0]   batch;
		logic                 forced;
		int                   last_idx;
		int                   emitted;
		sched_entry_t         entry;

		for (int a = 0; a < MAX_TASKS; a++)
			preds[a] = '0;
		for (int a = 0; a < held_count; a++) begin
			for (int b = a + 1; b < held_count; b++) begin
				if (held_phase[a] == held_phase[b]) begin
					if ((held_write[a] & held_read[b]) != '0 ||
						(held_write[a] & held_write[b]) != '0)
						preds[b][a] = 1'b1;
					if ((held_write[b] & held_read[a]) != '0)
						preds[a][b] = 1'b1;
				end
			end
		end

		done_set = '0;
		batch = '0;
		emitted = 0;
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			members = '0;
			for (int t = 0; t < held_count; t++)
				if (held_phase[t] == ph)
					members[t] = 1'b1;
			while ((members & ~done_set) != '0) begin
				open_set = members & ~done_set;
				ready_set = '0;
				for (int t = 0; t < held_count; t++)
					if (open_set[t] && (preds[t] & open_set) == '0)
						ready_set[t] = 1'b1;
				forced = (ready_set == '0);
				// A dependency cycle blocks the phase: release the lowest open task alone.
				if (forced)
					ready_set = open_set & (~open_set + 1'b1);
				last_idx = 0;
				for (int t = 0; t < held_count; t++)
					if (ready_set[t])
						last_idx = t;
				for (int t = 0; t < held_count; t++) begin
					if (ready_set[t]) begin
						entry.task_index      = t[TASK_IDX_W-1:0];
						entry.batch_number    = batch;
						entry.end_of_batch    = (t == last_idx);
						entry.cycle_forced    = forced;
						entry.end_of_schedule = 1'b0;
						planned_results = {planned_results, entry};
						emitted++;
					end
				end
				done_set |= ready_set;
				batch++;
			end
		end

		if (emitted > 0) begin
			entry = planned_results.pop_back();
			entry.end_of_schedule = 1'b1;
			planned_results = {planned_results, entry};
		end
		held_count = 0;
	endfunction

	// Store an accepted record; a full store drops it, but a last flag still builds.
	function void absorb_record(task_rec_t rec);
		if (held_count < MAX_TASKS) begin
			held_phase[held_count] = rec.task_phase;
			held_read[held_count]  = rec.read_mask;
			held_write[held_count] = rec.write_mask;
			held_count++;
		end
		if (rec.last_task)
			plan_schedule();
	endfunction

	function void add_record(logic [PHASE_W-1:0] ph, logic [MASK_W-1:0] rd,
		logic [MASK_W-1:0] wr, logic last);
		feed_item_t item;

		item.kind = FEED_RECORD;
		item.rec.task_phase = ph;
		item.rec.read_mask  = rd;
		item.rec.write_mask = wr;
		item.rec.last_task  = last;
		feed_queue = {feed_queue, item};
	endfunction

	function void add_marker(feed_kind_t kind);
		feed_item_t item;

		item.kind = kind;
		item.rec = '0;
		feed_queue = {feed_queue, item};
	endfunction

	// Masks are mostly sparse picks from a small resource pool so that hazards are common.
	function logic [MASK_W-1:0] rand_mask();
		logic [MASK_W-1:0] m;

		case ($urandom_range(0, 11))
			0: m = '0;
			1: m = '1;
			2, 3: m = {$urandom, $urandom};
			default: begin
				m = '0;
				repeat ($urandom_range(0, 2))
					m[res_pos[$urandom_range(0, 3)]] = 1'b1;
			end
		endcase
		return m;
	endfunction

	function void add_schedule(int len, int phase_top);
		foreach (res_pos[i])
			res_pos[i] = $urandom_range(0, MASK_W - 1);
		for (int i = 0; i < len; i++)
			add_record(PHASE_W'($urandom_range(0, phase_top)), rand_mask(), rand_mask(),
				i == len - 1);
	endfunction

	// Task record driver: bursts of transactions separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tasks_ch.valid      <= 1'b0;
			tasks_ch.task_phase <= '0;
			tasks_ch.read_mask  <= '0;
			tasks_ch.write_mask <= '0;
			tasks_ch.last_task  <= 1'b0;
			gap_left = 0;
			burst_left = 0;
		end else begin
			offering = tasks_ch.valid;
			if (tasks_ch.valid && tasks_ch.ready) begin
				absorb_record(on_offer);
				offering = 1'b0;
			end
			if (!offering && gap_left > 0) begin
				gap_left--;
			end else if (!offering && feed_queue.size() > 0) begin
				head = feed_queue[0];
				case (head.kind)
					FEED_HOLD: begin
						void'(feed_queue.pop_front());
						hold_token <= hold_token + 1;
					end
					FEED_DRAIN: begin
						if (planned_results.size() == 0)
							void'(feed_queue.pop_front());
					end
					default: begin
						void'(feed_queue.pop_front());
						on_offer = head.rec;
						tasks_ch.task_phase <= head.rec.task_phase;
						tasks_ch.read_mask  <= head.rec.read_mask;
						tasks_ch.write_mask <= head.rec.write_mask;
						tasks_ch.last_task  <= head.rec.last_task;
						offering = 1'b1;
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(1, 12);
							gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						end
					end
				endcase
			end
			tasks_ch.valid <= offering;
		end
	end

	// Result receiver: its own stall pattern, plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_ch.ready <= 1'b0;
			sink_mode = SINK_OPEN;
			mode_left = 0;
			hold_seen = 0;
			hold_left = 0;
		end else begin
			if (hold_seen != hold_token) begin
				hold_seen = hold_token;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				results_ch.ready <= 1'b0;
			end else begin
				case (sink_mode)
					SINK_OPEN:   results_ch.ready <= 1'b1;
					SINK_COIN:   results_ch.ready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: results_ch.ready <= ($urandom_range(0, 3) == 0);
					default:     results_ch.ready <= (mode_left % 8) < 5;
				endcase
			end
		end
	end

	// Result monitor: every transaction is checked against the oldest planned entry.
	always @(posedge clk) begin
		if (arst_n && results_ch.valid && results_ch.ready) begin
			if (planned_results.size() == 0) begin
				flag_mismatch($sformatf("result task %0d with nothing planned",
					results_ch.task_index));
			end else begin
				sched_entry_t want;
				want = planned_results.pop_front();
				if (results_ch.task_index !== want.task_index)
					flag_mismatch($sformatf("task_index got %0d want %0d",
						results_ch.task_index, want.task_index));
				if (results_ch.batch_number !== want.batch_number)
					flag_mismatch($sformatf("batch_number got %0d want %0d (task %0d)",
						results_ch.batch_number, want.batch_number, want.task_index));
				if (results_ch.end_of_batch !== want.end_of_batch)
					flag_mismatch($sformatf("end_of_batch got %b want %b (task %0d)",
						results_ch.end_of_batch, want.end_of_batch, want.task_index));
				if (results_ch.cycle_forced !== want.cycle_forced)
					flag_mismatch($sformatf("cycle_forced got %b want %b (task %0d)",
						results_ch.cycle_forced, want.cycle_forced, want.task_index));
				if (results_ch.end_of_schedule !== want.end_of_schedule)
					flag_mismatch($sformatf("end_of_schedule got %b want %b (task %0d)",
						results_ch.end_of_schedule, want.end_of_schedule, want.task_index));
			end
		end
	end

	// Watchdog: too long without any transaction on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (tasks_ch.valid && tasks_ch.ready) ||
			(results_ch.valid && results_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int rand_items;
		int sched_no;
		int len;

		clk = 1'b0;
		arst_n = 1'b0;
		tasks_ch.valid = 1'b0;
		tasks_ch.task_phase = '0;
		tasks_ch.read_mask = '0;
		tasks_ch.write_mask = '0;
		tasks_ch.last_task = 1'b0;
		results_ch.ready = 1'b0;
		hold_token = 0;
		quiet_cycles = 0;
		held_count = 0;
		fail_count = 0;

		// Lone task with empty masks.
		add_record(2'd0, '0, '0, 1'b1);
		// Full masks in the top phase form a two-task cycle; phases 0 and 1 stay empty.
		add_record(2'd3, '1, '1, 1'b0);
		add_record(2'd3, '1, '1, 1'b0);
		add_record(2'd2, '0, '0, 1'b1);
		// Read-after-write chain over the edge bits plus an independent task.
		add_record(2'd1, '0, 64'h8000_0000_0000_0000, 1'b0);
		add_record(2'd1, 64'h8000_0000_0000_0000, 64'h1, 1'b0);
		add_record(2'd1, 64'h1, '0, 1'b0);
		add_record(2'd1, 64'h0F0, 64'hF00, 1'b1);
		// Write-after-read ordering, then alternating masks that hazard both ways.
		add_record(2'd0, 64'h20, '0, 1'b0);
		add_record(2'd0, '0, 64'h20, 1'b0);
		add_record(2'd2, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
		add_record(2'd2, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b1);
		add_marker(FEED_DRAIN);
		// Three-task ring broken by forcing, behind a task that is ready at once.
		add_record(2'd1, 64'h4, 64'h1, 1'b0);
		add_record(2'd1, 64'h1, 64'h2, 1'b0);
		add_record(2'd1, 64'h2, 64'h4, 1'b0);
		add_record(2'd1, '0, '0, 1'b1);

		// Random schedules, mostly short; two overflow the store and one fills it exactly.
		rand_items = 0;
		sched_no = 0;
		while (rand_items < RANDOM_ITEMS) begin
			sched_no++;
			if (sched_no == 4 || sched_no == 18)
				len = $urandom_range(MAX_TASKS + 1, MAX_TASKS + 2);
			else if (sched_no == 11)
				len = MAX_TASKS;
			else if ($urandom_range(0, 4) == 0)
				len = $urandom_range(9, 16);
			else
				len = $urandom_range(1, 8);
			if (sched_no == 8)
				add_marker(FEED_HOLD);
			add_schedule(len, $urandom_range(0, PHASE_COUNT - 1));
			rand_items += len;
			if ($urandom_range(0, 5) == 0)
				add_marker(FEED_DRAIN);
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (feed_queue.size() > 0 || tasks_ch.valid || planned_results.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (planned_results.size() != 0)
			flag_mismatch($sformatf("%0d planned results never arrived",
				planned_results.size()));
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- hazard_batch_scheduler_unit.f -----
+incdir+rtl/core
rtl/core/hbs_pkg.sv
rtl/core/hbs_if.sv
rtl/core/hbs_ctrl.sv
rtl/core/hbs_datapath.sv
rtl/core/hazard_batch_scheduler_unit.sv
rtl/core/hbs_checker.sv
sim/hazard_batch_scheduler_unit_tb.sv
